// ===== rtl/core/cidlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidlp_pkg
// Shared types and constants of the caller ID line parser.
// ----------------------------------------------------------------------------
package cidlp_pkg;

   localparam logic [7:0]  CH_CR      = 8'd13;
   localparam logic [7:0]  CH_LF      = 8'd10;
   localparam int          PAYLOAD_AT = 7;
   localparam int          TAG_BYTES  = 4;
   localparam int          PAIR_MIN   = 4;

   localparam logic [31:0] TAG_DATE   = 32'h4441_5445;
   localparam logic [31:0] TAG_TIME   = 32'h5449_4D45;
   localparam logic [31:0] TAG_NMBR   = 32'h4E4D_4252;

   // Wide enough for any supported number length (up to 32) and its count.
   localparam int          LEN_W      = 6;
   localparam int          POS_W      = 5;

   localparam logic [1:0]  CMD_DATE   = 2'd0;
   localparam logic [1:0]  CMD_TIME   = 2'd1;
   localparam logic [1:0]  CMD_NMBR   = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [LEN_W-1:0] len;
      logic [31:0]      text;
   } cmd_type;

endpackage

// ===== rtl/core/cidlp_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidlp_req_if / cidlp_rsp_if
// Valid/ready channels carrying received bytes and record results.
// ----------------------------------------------------------------------------
interface cidlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cidlp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] day_text;
   logic [15:0] month_text;
   logic [15:0] hour_text;
   logic [15:0] minute_text;
   logic [7:0]  number_char;
   logic        number_valid;
   logic [4:0]  char_position;
   logic        last;

   modport source (output valid, output day_text, output month_text, output hour_text,
                   output minute_text, output number_char, output number_valid,
                   output char_position, output last, input ready);
   modport sink   (input valid, input day_text, input month_text, input hour_text,
                   input minute_text, input number_char, input number_valid,
                   input char_position, input last, output ready);
endinterface

// ===== rtl/core/cidlp_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidlp_cmd_fifo
// Two-entry command queue between the line front end and the record back end.
// ----------------------------------------------------------------------------
module cidlp_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cidlp_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output cidlp_pkg::cmd_type head_cmd
);
   import cidlp_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/cidlp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidlp_front
// Collects line bytes, captures tag and payload, classifies each line at its
// carriage return and queues a command for the back end.
// ----------------------------------------------------------------------------
module cidlp_front #(
   parameter int LINE_MAX   = 100,
   parameter int NUMBER_MAX = 19
) (
   input  logic                     clock,
   input  logic                     reset,
   cidlp_req_if.sink                req_chan,
   output logic                     push,
   output cidlp_pkg::cmd_type       push_cmd,
   input  logic                     fifo_full,
   input  logic                     number_done,
   input  logic [cidlp_pkg::POS_W-1:0] rd_idx,
   output logic [7:0]               rd_data
);
   import cidlp_pkg::*;

   localparam int CW = $clog2(LINE_MAX + 1);
   localparam int LW = $clog2(NUMBER_MAX + 1);
   localparam int IW = $clog2(NUMBER_MAX);

   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   tag_ff, tag_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ended_ff, ended_in;
   logic          busy_ff, busy_in;
   logic [7:0]    store_ff [NUMBER_MAX];
   logic          store_we;

   logic          take;
   logic [7:0]    b;
   logic          examine;

   assign req_chan.ready = !busy_ff && !fifo_full;
   assign take           = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;
   assign rd_data        = store_ff[rd_idx[IW-1:0]];
   assign examine        = take && (b == CH_CR) && (count_ff > CW'(PAYLOAD_AT));

   always_comb begin
      count_in = count_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      ended_in = ended_ff;
      busy_in  = busy_ff;
      store_we = 1'b0;
      push     = 1'b0;
      push_cmd.kind = CMD_NMBR;
      push_cmd.len  = LEN_W'(len_ff);
      push_cmd.text = {store_ff[0], store_ff[1], store_ff[2], store_ff[3]};

      if (number_done) begin
         busy_in = 1'b0;
      end

      if (take && b != CH_LF) begin
         if (b != CH_CR) begin
            if (count_ff < CW'(LINE_MAX)) begin
               if (count_ff < CW'(TAG_BYTES)) begin
                  tag_in = {tag_ff[23:0], b};
               end else if (count_ff >= CW'(PAYLOAD_AT) && !ended_ff) begin
                  if (b == 8'd0) begin
                     ended_in = 1'b1;
                  end else if (len_ff < LW'(NUMBER_MAX)) begin
                     store_we = 1'b1;
                     len_in   = len_ff + 1'b1;
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (examine) begin
               if (tag_ff == TAG_DATE && len_ff >= LW'(PAIR_MIN)) begin
                  push          = 1'b1;
                  push_cmd.kind = CMD_DATE;
               end else if (tag_ff == TAG_TIME && len_ff >= LW'(PAIR_MIN)) begin
                  push          = 1'b1;
                  push_cmd.kind = CMD_TIME;
               end else if (tag_ff == TAG_NMBR) begin
                  // hold off new bytes until the back end has read the store
                  push          = 1'b1;
                  push_cmd.kind = CMD_NMBR;
                  busy_in       = 1'b1;
               end
            end
            count_in = '0;
            tag_in   = '0;
            len_in   = '0;
            ended_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tag_ff   <= '0;
         len_ff   <= '0;
         ended_ff <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         ended_ff <= ended_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[len_ff[IW-1:0]] <= b;
      end
   end

endmodule

// ===== rtl/core/cidlp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidlp_back
// Executes queued commands: updates date and time pairs, and streams the
// caller number one character per word through a registered output.
// ----------------------------------------------------------------------------
module cidlp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fifo_empty,
   input  cidlp_pkg::cmd_type          head_cmd,
   output logic                        pop,
   output logic                        number_done,
   output logic [cidlp_pkg::POS_W-1:0] rd_idx,
   input  logic [7:0]                  rd_data,
   cidlp_rsp_if.source                 rsp_chan
);
   import cidlp_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic             state_ff, state_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [15:0]      day_ff, day_in;
   logic [15:0]      month_ff, month_in;
   logic [15:0]      hour_ff, hour_in;
   logic [15:0]      minute_ff, minute_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_nv_ff, out_nv_in;
   logic [POS_W-1:0] out_pos_ff, out_pos_in;
   logic             out_last_ff, out_last_in;
   logic [15:0]      out_day_ff, out_month_ff, out_hour_ff, out_minute_ff;

   logic             slot_free;
   logic             load;
   logic             is_last;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign rd_idx    = idx_ff;
   assign is_last   = ({1'b0, idx_ff} + LEN_W'(1)) == len_ff;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      day_in      = day_ff;
      month_in    = month_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      pop         = 1'b0;
      number_done = 1'b0;
      load        = 1'b0;
      out_char_in = rd_data;
      out_nv_in   = 1'b1;
      out_pos_in  = idx_ff;
      out_last_in = is_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               unique case (head_cmd.kind)
                  CMD_DATE: begin
                     pop      = 1'b1;
                     day_in   = head_cmd.text[31:16];
                     month_in = head_cmd.text[15:0];
                  end
                  CMD_TIME: begin
                     pop       = 1'b1;
                     hour_in   = head_cmd.text[31:16];
                     minute_in = head_cmd.text[15:0];
                  end
                  CMD_NMBR: begin
                     if (head_cmd.len == '0) begin
                        // empty number: one word with no character
                        if (slot_free) begin
                           pop         = 1'b1;
                           load        = 1'b1;
                           number_done = 1'b1;
                           out_char_in = 8'd0;
                           out_nv_in   = 1'b0;
                           out_pos_in  = '0;
                           out_last_in = 1'b1;
                        end
                     end else begin
                        pop      = 1'b1;
                        idx_in   = '0;
                        len_in   = head_cmd.len;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load   = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (is_last) begin
                  number_done = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         len_ff       <= '0;
         day_ff       <= '0;
         month_ff     <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_char_ff   <= out_char_in;
         out_nv_ff     <= out_nv_in;
         out_pos_ff    <= out_pos_in;
         out_last_ff   <= out_last_in;
         out_day_ff    <= day_ff;
         out_month_ff  <= month_ff;
         out_hour_ff   <= hour_ff;
         out_minute_ff <= minute_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.day_text      = out_day_ff;
   assign rsp_chan.month_text    = out_month_ff;
   assign rsp_chan.hour_text     = out_hour_ff;
   assign rsp_chan.minute_text   = out_minute_ff;
   assign rsp_chan.number_char   = out_char_ff;
   assign rsp_chan.number_valid  = out_nv_ff;
   assign rsp_chan.char_position = out_pos_ff;
   assign rsp_chan.last          = out_last_ff;

endmodule

// ===== rtl/core/caller_id_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caller_id_line_parser
// Parses modem caller ID text lines and emits one word per number character.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle unless the command queue is full; a
//   number record streams one word per cycle from the output register unless the
//   output is stalled, and input stalls from its carriage return until its last
//   word is loaded there (the back end reads the shared payload store).
// Path: a number word passes the command queue, the back-end step and the output
//   register; an empty number skips the back-end step.
// Reset: synchronous; clears line state, stored pairs, queue and output valid.
module caller_id_line_parser #(
   parameter int LINE_MAX   = 100,
   parameter int NUMBER_MAX = 19
) (
   input  logic        clock,
   input  logic        reset,
   cidlp_req_if.sink   req_chan,
   cidlp_rsp_if.source rsp_chan
);
   import cidlp_pkg::*;

   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;
   logic             fifo_full;
   logic             fifo_empty;
   logic             number_done;
   logic [POS_W-1:0] rd_idx;
   logic [7:0]       rd_data;

   cidlp_front #(
      .LINE_MAX   (LINE_MAX),
      .NUMBER_MAX (NUMBER_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .push        (push),
      .push_cmd    (push_cmd),
      .fifo_full   (fifo_full),
      .number_done (number_done),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data)
   );

   cidlp_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .empty    (fifo_empty),
      .head_cmd (head_cmd)
   );

   cidlp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .number_done (number_done),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== tb/cidlp_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidlp_record_checker
// Watches the byte and number word channels of the caller ID line parser,
// tracks the line and stored date/time state of the parser on every accepted
// byte, and compares every accepted number word with the oldest predicted one.
// ----------------------------------------------------------------------------
module cidlp_record_checker #(
   parameter int LINE_MAX   = 100,
   parameter int NUMBER_MAX = 19
) (
   input  logic  clock,
   input  logic  reset,
   cidlp_req_if  req_mon,
   cidlp_rsp_if  rsp_mon,
   output int    mismatches,
   output int    words_pending
);
   import cidlp_pkg::*;

   typedef struct packed {
      logic [15:0] day_text;
      logic [15:0] month_text;
      logic [15:0] hour_text;
      logic [15:0] minute_text;
      logic [7:0]  number_char;
      logic        number_valid;
      logic [4:0]  char_position;
      logic        last;
   } caller_word_type;

   caller_word_type  expected_words[$];

   logic [6:0]       kept_len;
   logic [31:0]      tag_word;
   logic [LEN_W-1:0] digit_count;
   logic             digits_closed;
   logic [7:0]       digit_buf[NUMBER_MAX];
   logic [15:0]      held_day;
   logic [15:0]      held_month;
   logic [15:0]      held_hour;
   logic [15:0]      held_minute;

   function automatic string word_text(input caller_word_type w);
      return $sformatf("day %h month %h hour %h minute %h char %h valid %b pos %0d last %b",
                       w.day_text, w.month_text, w.hour_text, w.minute_text,
                       w.number_char, w.number_valid, w.char_position, w.last);
   endfunction

   task automatic clear_line();
      kept_len      = '0;
      tag_word      = '0;
      digit_count   = '0;
      digits_closed = 1'b0;
   endtask

   task automatic queue_word(input logic [7:0] ch, input logic ok, input logic [4:0] pos,
                             input logic fin);
      caller_word_type w;
      w.day_text      = held_day;
      w.month_text    = held_month;
      w.hour_text     = held_hour;
      w.minute_text   = held_minute;
      w.number_char   = ch;
      w.number_valid  = ok;
      w.char_position = pos;
      w.last          = fin;
      expected_words.push_back(w);
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      if (b == CH_LF)
         return;
      if (b != CH_CR) begin
         // keep at most LINE_MAX bytes, drop the rest of an overlong line
         if (kept_len < LINE_MAX) begin
            if (kept_len < TAG_BYTES) begin
               tag_word = {tag_word[23:0], b};
            end else if (kept_len >= PAYLOAD_AT && !digits_closed) begin
               if (b == 8'h00) begin
                  digits_closed = 1'b1;
               end else if (digit_count < NUMBER_MAX) begin
                  digit_buf[digit_count] = b;
                  digit_count++;
               end
            end
            kept_len++;
         end
         return;
      end
      if (kept_len > PAYLOAD_AT) begin
         if (tag_word == TAG_DATE) begin
            if (digit_count >= PAIR_MIN) begin
               held_day   = {digit_buf[0], digit_buf[1]};
               held_month = {digit_buf[2], digit_buf[3]};
            end
         end else if (tag_word == TAG_TIME) begin
            if (digit_count >= PAIR_MIN) begin
               held_hour   = {digit_buf[0], digit_buf[1]};
               held_minute = {digit_buf[2], digit_buf[3]};
            end
         end else if (tag_word == TAG_NMBR) begin
            if (digit_count == 0) begin
               queue_word(8'h00, 1'b0, 5'd0, 1'b1);
            end else begin
               for (int i = 0; i < digit_count; i++)
                  queue_word(digit_buf[i], 1'b1, 5'(i), (i == digit_count - 1));
            end
         end
      end
      clear_line();
   endtask

   task automatic check_word(input caller_word_type got);
      caller_word_type want;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] unexpected number word: %s", $time, word_text(got));
         return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] number word mismatch", $time);
            $display("   expected %s", word_text(want));
            $display("   actual   %s", word_text(got));
         end
      end
   endtask

   initial begin
      mismatches    = 0;
      words_pending = 0;
   end

   // Sample half a cycle ahead: everything settles after the rising edge, so
   // the values seen here are the ones the next edge will take.
   always @(negedge clock) begin
      caller_word_type got;
      if (reset) begin
         clear_line();
         held_day    = '0;
         held_month  = '0;
         held_hour   = '0;
         held_minute = '0;
         expected_words.delete();
      end else begin
         // drain the output first: a word leaving now cannot stem from this byte
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.day_text      = rsp_mon.day_text;
            got.month_text    = rsp_mon.month_text;
            got.hour_text     = rsp_mon.hour_text;
            got.minute_text   = rsp_mon.minute_text;
            got.number_char   = rsp_mon.number_char;
            got.number_valid  = rsp_mon.number_valid;
            got.char_position = rsp_mon.char_position;
            got.last          = rsp_mon.last;
            check_word(got);
         end
         if (req_mon.valid && req_mon.ready)
            absorb_byte(req_mon.rx_byte);
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== tb/tb_caller_id_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_caller_id_line_parser
// Feeds modem text lines (date, time and number records, short, overlong and
// malformed lines, raw noise) to the caller ID line parser under changing
// idle and back-pressure patterns; a checker beside the block predicts and
// compares the number words.
// ----------------------------------------------------------------------------
module tb_caller_id_line_parser;
   import cidlp_pkg::*;

   localparam int LINE_MAX    = 100;
   localparam int NUMBER_MAX  = 19;
   localparam int ITEM_GOAL   = 310;
   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN       = 16;

   logic clock;
   logic reset;

   cidlp_req_if req_chan ();
   cidlp_rsp_if rsp_chan ();

   int         mismatches;
   int         words_pending;
   int         tx_idle_pct;
   int         rx_stall_pct;
   int         items_sent;
   int         idle_cycles;
   bit         hold_req;
   bit         hold_done;
   logic [7:0] line_buf[$];

   int tx_idle_by_phase[4]  = '{0, 80, 0, 11};
   int rx_stall_by_phase[4] = '{0, 0, 80, 11};

   caller_id_line_parser #(
      .LINE_MAX   (LINE_MAX),
      .NUMBER_MAX (NUMBER_MAX)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cidlp_record_checker #(
      .LINE_MAX   (LINE_MAX),
      .NUMBER_MAX (NUMBER_MAX)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .mismatches    (mismatches),
      .words_pending (words_pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // --- byte sender ---------------------------------------------------------

   task automatic drive_byte(input logic [7:0] b);
      logic taken;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end
      if (b != CH_LF)
         items_sent++;
   endtask

   task automatic flush_line();
      foreach (line_buf[i])
         drive_byte(line_buf[i]);
      line_buf.delete();
   endtask

   // hold the sender until every predicted word has come out
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (words_pending != 0)
         @(posedge clock);
   endtask

   // --- line builders -------------------------------------------------------

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == CH_CR || b == CH_LF);
      return b;
   endfunction

   function automatic logic [31:0] pick_tag();
      int roll;
      roll = $urandom_range(3);
      return (roll == 0) ? TAG_DATE : (roll == 1) ? TAG_TIME : TAG_NMBR;
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(s[i]);
   endtask

   task automatic put_tag(input logic [31:0] tag);
      for (int i = 3; i >= 0; i--)
         line_buf.push_back(tag[8*i +: 8]);
   endtask

   task automatic put_digits(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 5)
            line_buf.push_back(CH_LF);
         if ($urandom_range(99) < 80)
            line_buf.push_back(8'h30 + 8'($urandom_range(9)));
         else if ($urandom_range(99) < 10)
            line_buf.push_back(8'h00);
         else
            line_buf.push_back(text_byte());
      end
   endtask

   task automatic end_line();
      line_buf.push_back(CH_CR);
      if ($urandom_range(1) == 1)
         line_buf.push_back(CH_LF);
   endtask

   task automatic make_record_line(input logic [31:0] tag);
      int n;
      put_tag(tag);
      if ($urandom_range(99) < 85)
         put_text(" = ");
      else
         repeat (3) line_buf.push_back(text_byte());
      // a leading zero closes the payload: empty number
      if ($urandom_range(99) < 8)
         line_buf.push_back(8'h00);
      if ($urandom_range(99) < 7)
         n = $urandom_range(LINE_MAX + 25, LINE_MAX - 10);
      else if (tag == TAG_NMBR)
         n = $urandom_range(NUMBER_MAX + 5);
      else
         n = $urandom_range(8);
      put_digits(n);
      end_line();
   endtask

   task automatic make_noise_line();
      logic [31:0] tag;
      int          pick;
      pick = $urandom_range(2);
      tag  = pick_tag();
      case (pick)
         0: begin
            // near-miss tag: one bit off
            put_tag(tag ^ (32'd1 << $urandom_range(31)));
            put_text(" = ");
            put_digits($urandom_range(12));
         end
         1: begin
            put_tag(tag);
            repeat ($urandom_range(3)) line_buf.push_back(text_byte());
         end
         default: begin
            repeat ($urandom_range(14, 1)) line_buf.push_back(8'($urandom_range(255)));
         end
      endcase
      end_line();
   endtask

   // --- receiver ------------------------------------------------------------

   initial begin
      rsp_chan.ready = 1'b0;
      hold_done      = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // --- watchdog ------------------------------------------------------------

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("** caller_id_line_parser: FAILED **");
      $finish;
   end

   // --- stimulus ------------------------------------------------------------

   initial begin
      int start_items;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      hold_req         = 1'b0;
      tx_idle_pct      = 0;
      rx_stall_pct     = 0;
      items_sent       = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      put_text("DATE = 0321");
      end_line();
      put_text("TIME = ");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      line_buf.push_back(8'h7F);
      line_buf.push_back(8'h01);
      end_line();
      put_text("NMBR = 5551234");
      end_line();
      put_text("NMBR = ");
      line_buf.push_back(8'h00);
      end_line();
      put_text("DATE = 12");
      end_line();
      put_text("TIME = 0945");
      end_line();
      put_text("NMBR=");
      end_line();
      put_text("NM");
      line_buf.push_back(8'h00);
      put_text("R = 7");
      end_line();
      put_text("NMBR = 9");
      end_line();
      flush_line();
      wait_drained();

      start_items = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         tx_idle_pct  = tx_idle_by_phase[phase];
         rx_stall_pct = rx_stall_by_phase[phase];
         if (phase == 0) begin
            // stall the output while number records keep coming in
            hold_req = 1'b1;
            repeat (3) begin
               put_text("NMBR = ");
               put_digits(NUMBER_MAX);
               end_line();
               flush_line();
            end
         end
         while (items_sent < start_items + (phase + 1) * (ITEM_GOAL - start_items) / 4) begin
            if ($urandom_range(99) < 75)
               make_record_line(pick_tag());
            else
               make_noise_line();
            flush_line();
         end
         wait_drained();
      end

      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0)
         $display("** caller_id_line_parser: PASSED **");
      else
         $display("** caller_id_line_parser: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/cidlp_pkg.sv
rtl/core/cidlp_ifs.sv
rtl/core/cidlp_cmd_fifo.sv
rtl/core/cidlp_front.sv
rtl/core/cidlp_back.sv
rtl/core/caller_id_line_parser.sv
tb/cidlp_record_checker.sv
tb/tb_caller_id_line_parser.sv
